/* hw/rtl/stepper_ramp_position_controller_macros.svh */
// Assertion macros for the stepper ramp position controller checker
`ifndef STEPPER_RAMP_POSITION_CONTROLLER_MACROS_SVH
`define STEPPER_RAMP_POSITION_CONTROLLER_MACROS_SVH

// same-cycle implication, masked during reset
`define SRPC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked during reset
`define SRPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, checked through reset
`define SRPC_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/srpc_pkg.sv */
// Shared types and constants of the stepper ramp position controller
package srpc_pkg;

    localparam int ACT_W     = 2;
    localparam int TGT_W     = 32;
    localparam int IDX_W     = 12;
    localparam int DLY_IN_W  = 24;
    localparam int CFG_W     = 13;
    localparam int POS_W     = 32;
    localparam int DIR_W     = 2;
    localparam int S_TDATA_W = 72;

    typedef enum logic [ACT_W-1:0] {
        ACT_TICK   = 2'd0,
        ACT_TARGET = 2'd1,
        ACT_ENTRY  = 2'd2
    } act_t;

    typedef enum logic [DIR_W-1:0] {
        DIR_HOLD = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_BWD  = 2'd2
    } dir_t;

    typedef struct packed {
        logic tick;
        logic set_tgt;
    } ctl_t;

endpackage

/* hw/rtl/srpc_dly_mem.sv */
// Delay table memory, one write port, one registered read port
module srpc_dly_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 24
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/srpc_ramp.sv */
// Ramp state (position, target, speed index, table length) and step decision
module srpc_ramp #(
    parameter int TABLE_DEPTH = 4096,
    parameter int AW          = 12,
    parameter int SW          = 13
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [srpc_pkg::CFG_W-1:0]     cfg_wdata,
    input  srpc_pkg::ctl_t                 ctl,
    input  logic [srpc_pkg::TGT_W-1:0]     target_value,
    output logic [AW-1:0]                  rd_addr,
    output srpc_pkg::dir_t                 dir_next,
    output logic [srpc_pkg::POS_W-1:0]     pos_next,
    output logic signed [SW-1:0]           spd_next
);

    logic [srpc_pkg::CFG_W-1:0] len_reg;
    logic [srpc_pkg::POS_W-1:0] pos_reg;
    logic [srpc_pkg::TGT_W-1:0] tgt_reg;
    logic signed [SW-1:0]       spd_reg;

    logic [SW-1:0]        mag;
    logic [AW-1:0]        lim;
    logic signed [SW:0]   lim_s;
    logic signed [SW:0]   spd_p1;
    logic signed [SW:0]   spd_m1;
    logic signed [32:0]   sum;
    logic signed [32:0]   ps;
    logic signed [32:0]   tx;
    logic                 s_pos;
    logic                 s_neg;
    logic signed [SW:0]   spd_sel;

    always_comb begin
        mag     = spd_reg[SW-1] ? SW'(-spd_reg) : SW'(spd_reg);
        rd_addr = mag[AW-1:0];

        if (len_reg == '0) begin
            lim = '0;
        end else if (17'(len_reg) > 17'(TABLE_DEPTH)) begin
            lim = AW'(TABLE_DEPTH - 1);
        end else begin
            lim = AW'(len_reg - 13'd1);
        end
        lim_s = $signed({{(SW + 1 - AW){1'b0}}, lim});

        spd_p1 = $signed({spd_reg[SW-1], spd_reg}) + $signed((SW + 1)'(1));
        spd_m1 = $signed({spd_reg[SW-1], spd_reg}) - $signed((SW + 1)'(1));
        ps     = $signed({pos_reg[31], pos_reg});
        tx     = $signed({tgt_reg[31], tgt_reg});
        sum    = ps + $signed({{(33 - SW){spd_reg[SW-1]}}, spd_reg});
        s_neg  = spd_reg[SW-1];
        s_pos  = !spd_reg[SW-1] && (spd_reg != '0);

        if (s_pos && sum > tx) begin
            dir_next = srpc_pkg::DIR_FWD;
            spd_sel  = spd_m1;
        end else if (s_neg && sum < tx) begin
            dir_next = srpc_pkg::DIR_BWD;
            spd_sel  = spd_p1;
        end else if (sum < tx) begin
            dir_next = srpc_pkg::DIR_FWD;
            spd_sel  = (spd_p1 < lim_s) ? spd_p1 : lim_s;
        end else if (ps < tx && tx <= sum) begin
            dir_next = srpc_pkg::DIR_FWD;
            spd_sel  = spd_m1;
        end else if (sum > tx) begin
            dir_next = srpc_pkg::DIR_BWD;
            spd_sel  = (spd_m1 > -lim_s) ? spd_m1 : -lim_s;
        end else if (ps > tx && tx >= sum) begin
            dir_next = srpc_pkg::DIR_BWD;
            spd_sel  = spd_p1;
        end else begin
            dir_next = srpc_pkg::DIR_HOLD;
            spd_sel  = $signed({spd_reg[SW-1], spd_reg});
        end
        spd_next = spd_sel[SW-1:0];

        case (dir_next)
            srpc_pkg::DIR_FWD: pos_next = pos_reg + 32'd1;
            srpc_pkg::DIR_BWD: pos_next = pos_reg - 32'd1;
            default:           pos_next = pos_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= 13'd1;
            pos_reg <= '0;
            tgt_reg <= '0;
            spd_reg <= '0;
        end else begin
            if (cfg_we) begin
                len_reg <= cfg_wdata;
            end
            if (ctl.set_tgt) begin
                tgt_reg <= target_value;
            end
            if (ctl.tick) begin
                pos_reg <= pos_next;
                spd_reg <= spd_next;
            end
        end
    end

endmodule

/* hw/rtl/stepper_ramp_position_controller.sv */
// Top level of the stepper ramp position controller
//
//   port group   dir   word contents
//   s_axis       in    tuser: action; tdata: target, entry index, entry delay
//   m_axis       out   tdata: step dir, delay, position, speed (tick only)
//   cfg          in    table length
//
// One word per cycle on the input while s_tready is high; m_tvalid rises after a
// tick is accepted (table read at acceptance, output register loaded once the output is free).
// Speed and position update at acceptance, so ticks may arrive back to back.
// Synchronous active-low reset clears state; table contents are not cleared.
// A stalled output holds one result in the output register and one in the
// read stage before the input stalls.
module stepper_ramp_position_controller #(
    parameter int TABLE_DEPTH = 4096,
    parameter int DELAY_BITS  = 24
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [srpc_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [srpc_pkg::S_TDATA_W-1:0]   s_tdata,  // target_value, entry_index, entry_delay
    input  logic [srpc_pkg::ACT_W-1:0]       s_tuser,  // action
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [((srpc_pkg::DIR_W + DELAY_BITS + srpc_pkg::POS_W
                    + $clog2(TABLE_DEPTH) + 1 + 7) / 8) * 8 - 1:0]
                                             m_tdata   // step_dir, delay_us, position_now, speed_now
);

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int SW    = AW + 1;
    localparam int OUT_W = srpc_pkg::DIR_W + DELAY_BITS + srpc_pkg::POS_W + SW;
    localparam int M_W   = ((OUT_W + 7) / 8) * 8;

    srpc_pkg::act_t              act;
    srpc_pkg::ctl_t              ctl;
    logic                        accept;
    logic [srpc_pkg::TGT_W-1:0]  in_target;
    logic [srpc_pkg::IDX_W-1:0]  in_idx;
    logic [srpc_pkg::DLY_IN_W-1:0] in_delay;
    logic                        wr_en;
    logic [AW-1:0]               rd_addr;
    logic [DELAY_BITS-1:0]       rdata;
    srpc_pkg::dir_t              dir_next;
    logic [srpc_pkg::POS_W-1:0]  pos_next;
    logic signed [SW-1:0]        spd_next;

    logic                        st_vld_reg, st_vld_next;
    srpc_pkg::dir_t              st_dir_reg;
    logic [srpc_pkg::POS_W-1:0]  st_pos_reg;
    logic [SW-1:0]               st_spd_reg;
    logic                        m_vld_reg, m_vld_next;
    logic [M_W-1:0]              m_data_reg;
    logic                        out_free;
    logic                        adv;
    logic [DELAY_BITS-1:0]       out_delay;

    assign act       = srpc_pkg::act_t'(s_tuser);
    assign in_target = s_tdata[srpc_pkg::TGT_W-1:0];
    assign in_idx    = s_tdata[srpc_pkg::TGT_W +: srpc_pkg::IDX_W];
    assign in_delay  = s_tdata[srpc_pkg::TGT_W + srpc_pkg::IDX_W +: srpc_pkg::DLY_IN_W];

    assign out_free = !m_vld_reg || m_tready;
    assign adv      = st_vld_reg && out_free;
    assign s_tready = !st_vld_reg || out_free;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        ctl   = '0;
        wr_en = 1'b0;
        case (act)
            srpc_pkg::ACT_TICK:   ctl.tick    = accept;
            srpc_pkg::ACT_TARGET: ctl.set_tgt = accept;
            srpc_pkg::ACT_ENTRY:  wr_en = accept && (17'(in_idx) < 17'(TABLE_DEPTH));
            default:              ctl   = '0;
        endcase
    end

    srpc_dly_mem #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW),
        .DW    (DELAY_BITS)
    ) u_mem (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (AW'(in_idx)),
        .wdata (DELAY_BITS'(in_delay)),
        .re    (ctl.tick),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    srpc_ramp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW),
        .SW          (SW)
    ) u_ramp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .ctl          (ctl),
        .target_value (in_target),
        .rd_addr      (rd_addr),
        .dir_next     (dir_next),
        .pos_next     (pos_next),
        .spd_next     (spd_next)
    );

    always_comb begin
        st_vld_next = st_vld_reg;
        if (ctl.tick) begin
            st_vld_next = 1'b1;
        end else if (adv) begin
            st_vld_next = 1'b0;
        end
        m_vld_next = m_vld_reg;
        if (adv) begin
            m_vld_next = 1'b1;
        end else if (m_tready) begin
            m_vld_next = 1'b0;
        end
        out_delay = (st_dir_reg == srpc_pkg::DIR_HOLD) ? '0 : rdata;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_vld_reg <= 1'b0;
            m_vld_reg  <= 1'b0;
        end else begin
            st_vld_reg <= st_vld_next;
            m_vld_reg  <= m_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.tick) begin
            st_dir_reg <= dir_next;
            st_pos_reg <= pos_next;
            st_spd_reg <= spd_next;
        end
        if (adv) begin
            m_data_reg <= M_W'({st_spd_reg, st_pos_reg, out_delay, st_dir_reg});
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = m_data_reg;

endmodule

/* hw/rtl/srpc_checker.sv */
// Port-level checker for the stepper ramp position controller, with bind
`include "stepper_ramp_position_controller_macros.svh"

module srpc_checker #(
    parameter int TABLE_DEPTH = 4096,
    parameter int DELAY_BITS  = 24
) (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [((srpc_pkg::DIR_W + DELAY_BITS + srpc_pkg::POS_W
                   + $clog2(TABLE_DEPTH) + 1 + 7) / 8) * 8 - 1:0] m_tdata
);

    `SRPC_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    `SRPC_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata), "result changed while stalled")
    `SRPC_ASSERT_NOW(a_dir_code, m_tvalid, m_tdata[1:0] != 2'd3, "illegal step direction")
    `SRPC_ASSERT_NOW(a_hold_delay, m_tvalid && m_tdata[1:0] == 2'd0, m_tdata[DELAY_BITS+1:2] == '0, "hold word carries a delay")
    `SRPC_ASSERT_RST(a_rst_idle, !aresetn, !m_tvalid, "output valid right after reset")

endmodule

bind stepper_ramp_position_controller srpc_checker #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .DELAY_BITS  (DELAY_BITS)
) u_srpc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* bench/stepper_ramp_position_controller_tb.sv */
// Self-checking testbench for the stepper ramp position controller
module stepper_ramp_position_controller_tb;

    localparam int M_TDATA_W      = ((srpc_pkg::DIR_W + 24 + srpc_pkg::POS_W + 13 + 7) / 8) * 8;
    localparam int DEPTH          = 4096;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_WORDS   = 200;
    localparam logic [srpc_pkg::ACT_W-1:0] ACT_RESERVED = 2'd3;

    typedef struct packed {
        srpc_pkg::dir_t dir;
        logic [23:0]    delay;
        logic [31:0]    pos;
        logic [12:0]    spd;
    } step_t;

    logic                            aclk = 1'b0;
    logic                            aresetn;
    logic                            cfg_we;
    logic [srpc_pkg::CFG_W-1:0]      cfg_wdata;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [srpc_pkg::S_TDATA_W-1:0]  s_tdata;   // target_value, entry_index, entry_delay, zero pad
    logic [srpc_pkg::ACT_W-1:0]      s_tuser;   // action
    logic                            m_tvalid;
    logic                            m_tready;
    logic [M_TDATA_W-1:0]            m_tdata;   // step_dir, delay_us, position_now, speed_now, pad

    stepper_ramp_position_controller u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #1 aclk = ~aclk;

    // motion tracker state
    logic [23:0]  delay_mem [DEPTH];
    bit           entry_written [DEPTH];
    logic [31:0]  mot_pos;
    logic [31:0]  mot_tgt;
    int           mot_spd;
    logic [12:0]  tab_len;
    step_t        step_q [$];

    bit gapless;
    bit rx_hold;

    int mismatches;
    int words_sent;
    int useful_words;
    int ticks_sent;
    int results_seen;
    int fwd_seen;
    int bwd_seen;
    int hold_seen;
    int cfg_writes;
    int peak_speed;
    int quiet_cycles;

    // expected result of one accepted word, applied to the tracker state
    task automatic track_word(input logic [srpc_pkg::ACT_W-1:0] act,
                              input logic [srpc_pkg::S_TDATA_W-1:0] data);
        step_t          r;
        longint         p, t, s, sum;
        int             len, mag;
        logic [23:0]    dt;
        srpc_pkg::dir_t dir;
        if (act == srpc_pkg::ACT_TARGET) begin
            mot_tgt = data[31:0];
        end else if (act == srpc_pkg::ACT_ENTRY) begin
            delay_mem[data[43:32]]     = data[67:44];
            entry_written[data[43:32]] = 1'b1;
        end else if (act == srpc_pkg::ACT_TICK) begin
            len = (tab_len == 0) ? 1 : ((tab_len > DEPTH) ? DEPTH : int'(tab_len));
            mag = (mot_spd < 0) ? -mot_spd : mot_spd;
            dt  = delay_mem[mag];
            p   = longint'($signed(mot_pos));
            t   = longint'($signed(mot_tgt));
            s   = mot_spd;
            sum = p + s;
            if (s > 0 && sum > t) begin
                mot_spd = mot_spd - 1;
                dir = srpc_pkg::DIR_FWD;
            end else if (s < 0 && sum < t) begin
                mot_spd = mot_spd + 1;
                dir = srpc_pkg::DIR_BWD;
            end else if (sum < t) begin
                mot_spd = (mot_spd + 1 < len - 1) ? mot_spd + 1 : len - 1;
                dir = srpc_pkg::DIR_FWD;
            end else if (p < t && t <= sum) begin
                mot_spd = mot_spd - 1;
                dir = srpc_pkg::DIR_FWD;
            end else if (sum > t) begin
                mot_spd = (mot_spd - 1 > 1 - len) ? mot_spd - 1 : 1 - len;
                dir = srpc_pkg::DIR_BWD;
            end else if (p > t && t >= sum) begin
                mot_spd = mot_spd + 1;
                dir = srpc_pkg::DIR_BWD;
            end else begin
                dir = srpc_pkg::DIR_HOLD;
            end
            if (dir == srpc_pkg::DIR_FWD)
                mot_pos = mot_pos + 32'd1;
            else if (dir == srpc_pkg::DIR_BWD)
                mot_pos = mot_pos - 32'd1;
            else
                dt = '0;
            r.dir   = dir;
            r.delay = dt;
            r.pos   = mot_pos;
            r.spd   = mot_spd[12:0];
            step_q.push_back(r);
            mag = (mot_spd < 0) ? -mot_spd : mot_spd;
            if (mag > peak_speed)
                peak_speed = mag;
        end
    endtask

    function automatic logic [srpc_pkg::S_TDATA_W-1:0] rand_fields();
        logic [95:0] w;
        w = {$urandom, $urandom, $urandom};
        return {4'd0, w[67:0]};
    endfunction

    // called at a falling edge, returns at a falling edge with the word accepted
    task automatic send_word(input logic [srpc_pkg::ACT_W-1:0] act,
                             input logic [srpc_pkg::S_TDATA_W-1:0] data);
        int gap;
        gap = gapless ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = act;
        s_tdata  = data;
        do @(posedge aclk); while (!s_tready);
        track_word(act, data);
        words_sent++;
        if (act != ACT_RESERVED)
            useful_words++;
        if (act == srpc_pkg::ACT_TICK)
            ticks_sent++;
        @(negedge aclk);
    endtask

    task automatic send_target(input logic [31:0] tgt);
        send_word(srpc_pkg::ACT_TARGET, {40'd0, tgt});
    endtask

    task automatic send_entry(input logic [11:0] idx, input logic [23:0] dly);
        send_word(srpc_pkg::ACT_ENTRY, {4'd0, dly, idx, 32'd0});
    endtask

    // loads the entry about to be read if it was never written
    task automatic send_tick();
        int mag;
        mag = (mot_spd < 0) ? -mot_spd : mot_spd;
        if (!entry_written[mag])
            send_entry(mag[11:0], 24'($urandom_range(0, 24'hFFFFFF)));
        send_word(srpc_pkg::ACT_TICK, rand_fields());
    endtask

    task automatic settle_motion(input int cap);
        int n;
        n = 0;
        while (!(mot_spd == 0 && mot_pos == mot_tgt) && n < cap) begin
            send_tick();
            n++;
        end
    endtask

    task automatic wait_results_done();
        s_tvalid = 1'b0;
        do @(negedge aclk); while (step_q.size() != 0);
    endtask

    // waits for all results to drain before the table length is written
    task automatic write_table_length(input logic [srpc_pkg::CFG_W-1:0] v);
        wait_results_done();
        repeat (4) @(negedge aclk);
        cfg_wdata = v;
        cfg_we    = 1'b1;
        @(negedge aclk);
        cfg_we    = 1'b0;
        tab_len   = v;
        cfg_writes++;
    endtask

    task automatic test_table_extremes();
        send_word(ACT_RESERVED, rand_fields());
        send_entry(12'd0, 24'hFFFFFF);
        send_entry(12'd4095, 24'h000000);
        send_entry(12'hAAA, 24'h555555);
        send_entry(12'h555, 24'hAAAAAA);
        send_tick();
        send_target(32'h7FFF_FFFF);
        repeat (3) send_tick();
        send_word(ACT_RESERVED, {4'd0, 68'hF_FFFF_FFFF_FFFF_FFFF});
        send_target(32'h8000_0000);
        repeat (4) send_tick();
        send_target(32'd0);
        repeat (3) send_tick();
        write_table_length(13'd0);
        send_target(32'd3);
        repeat (4) send_tick();
        send_target(32'hFFFF_FFFF);
        repeat (5) send_tick();
    endtask

    task automatic test_ramp_and_overshoot();
        write_table_length(13'd8);
        send_target(mot_pos + 32'd25);
        settle_motion(200);
        send_target(mot_pos - 32'd25);
        settle_motion(200);
        send_target(mot_pos + 32'd40);
        repeat (10) send_tick();
        send_target(mot_pos);
        settle_motion(200);
        send_target(mot_pos - 32'd40);
        repeat (10) send_tick();
        send_target(mot_pos + 32'd2);
        settle_motion(200);
    endtask

    task automatic test_speed_snap();
        write_table_length(13'd40);
        send_target(mot_pos + 32'd2000);
        repeat (30) send_tick();
        write_table_length(13'd4);
        repeat (3) send_tick();
        send_target(mot_pos);
        settle_motion(200);
        write_table_length(13'd40);
        send_target(mot_pos - 32'd2000);
        repeat (30) send_tick();
        write_table_length(13'd4);
        repeat (3) send_tick();
        send_target(mot_pos);
        settle_motion(200);
    endtask

    task automatic test_length_limits();
        write_table_length(13'd8191);
        send_target(mot_pos + 32'd100000);
        repeat (30) send_tick();
        send_target(mot_pos);
        settle_motion(400);
        write_table_length(13'd4096);
        send_target(mot_pos - 32'd100000);
        repeat (20) send_tick();
        send_target(mot_pos);
        settle_motion(400);
        write_table_length(13'd2);
        send_target(mot_pos + 32'd6);
        settle_motion(50);
    endtask

    task automatic test_output_stall();
        write_table_length(13'd16);
        send_target(mot_pos + 32'd500);
        rx_hold = 1'b1;
        gapless = 1'b1;
        repeat (12) send_tick();
        gapless = 1'b0;
        send_target(mot_pos);
        settle_motion(200);
        wait_results_done();
    endtask

    task automatic test_random_moves();
        int goal, chunk_end, k, r;
        logic [31:0] tgt;
        goal = useful_words + RANDOM_WORDS;
        k = 0;
        while (useful_words < goal) begin
            case (k % 5)
                0: write_table_length(13'd4096);
                1: write_table_length(13'd1);
                2: write_table_length(13'd2);
                default: write_table_length(13'($urandom_range(3, 64)));
            endcase
            gapless = ($urandom_range(0, 3) == 0);
            chunk_end = useful_words + 50;
            while (useful_words < chunk_end) begin
                r = $urandom_range(0, 99);
                if (r < 6) begin
                    send_word(ACT_RESERVED, rand_fields());
                end else if (r < 14) begin
                    send_entry(12'($urandom_range(0, DEPTH - 1)),
                               24'($urandom_range(0, 24'hFFFFFF)));
                end else if (r < 19) begin
                    send_target($urandom);
                end else if (r < 34) begin
                    tgt = mot_pos + 32'($urandom_range(0, 120)) - 32'd60;
                    send_target(tgt);
                end else if (r < 36) begin
                    wait_results_done();
                end else begin
                    repeat ($urandom_range(1, 12)) send_tick();
                end
            end
            send_target(mot_pos);
            settle_motion(300);
            gapless = 1'b0;
            k++;
        end
    endtask

    // result side: per-word stall, long hold-off on request
    initial begin : rx_side
        int stall;
        m_tready = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (rx_hold) begin
                m_tready = 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge aclk);
                rx_hold = 1'b0;
            end
            stall = gapless ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin : result_check
        step_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            case (m_tdata[1:0])
                srpc_pkg::DIR_FWD: fwd_seen++;
                srpc_pkg::DIR_BWD: bwd_seen++;
                default:           hold_seen++;
            endcase
            if (step_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected word, expected none, got %0h", $time, m_tdata);
            end else begin
                want = step_q.pop_front();
                check_field("step_dir", 32'(want.dir), 32'(m_tdata[1:0]));
                check_field("delay_us", 32'(want.delay), 32'(m_tdata[25:2]));
                check_field("position_now", want.pos, m_tdata[57:26]);
                check_field("speed_now", 32'(want.spd), 32'(m_tdata[70:58]));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no traffic for %0d cycles, %0d words outstanding",
                     quiet_cycles, step_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = srpc_pkg::ACT_TICK;
        gapless   = 1'b0;
        rx_hold   = 1'b0;
        mot_pos   = '0;
        mot_tgt   = '0;
        mot_spd   = 0;
        tab_len   = 13'd1;
        for (int i = 0; i < DEPTH; i++) begin
            delay_mem[i]     = '0;
            entry_written[i] = 1'b0;
        end
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        test_table_extremes();
        test_ramp_and_overshoot();
        test_speed_snap();
        test_length_limits();
        test_output_stall();
        test_random_moves();

        wait_results_done();
        repeat (8) @(negedge aclk);
        $display("Sent %0d words (%0d ticks); checked %0d results: %0d fwd, %0d bwd, %0d hold",
                 words_sent, ticks_sent, results_seen, fwd_seen, bwd_seen, hold_seen);
        $display("Table length written %0d times; peak speed magnitude %0d; %0d mismatches",
                 cfg_writes, peak_speed, mismatches);
        if (mismatches == 0 && step_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/srpc_pkg.sv
hw/rtl/srpc_dly_mem.sv
hw/rtl/srpc_ramp.sv
hw/rtl/stepper_ramp_position_controller.sv
hw/rtl/srpc_checker.sv
bench/stepper_ramp_position_controller_tb.sv
